FILE: rtl/mdrf_pkg.sv
// mdrf_pkg: types, constants and sizes shared by the mesh duplicate/relay filter.
// No dependencies.
package mdrf_pkg;

  localparam int unsigned SEEN_DEPTH = 16;
  localparam int unsigned SEEN_AW    = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned ADDR_W = 48;
  localparam int unsigned ID_W   = 32;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned KIND_W = 3;
  localparam int unsigned CIDX_W = 3;

  localparam int unsigned IN_DATA_W  = 208;
  localparam int unsigned OUT_DATA_W = 128;

  localparam logic [BYTE_W-1:0] APP_COORD = 8'hFF;
  localparam logic [BYTE_W-1:0] APP_NODE  = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    K_RAW_PING = 3'd0,
    K_RAW_PONG = 3'd1,
    K_MESH     = 3'd2,
    K_LOAD     = 3'd3,
    K_IGNORE   = 3'd4
  } kind_e;

  typedef enum logic [CIDX_W-1:0] {
    CFG_OWN   = 3'd0,
    CFG_BCAST = 3'd1,
    CFG_COORD = 3'd2,
    CFG_PING  = 3'd3,
    CFG_PONG  = 3'd4,
    CFG_DATA  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [ADDR_W-1:0] own_address;
    logic [ADDR_W-1:0] broadcast_address;
    logic              is_coordinator;
    logic [BYTE_W-1:0] ping_type_code;
    logic [BYTE_W-1:0] pong_type_code;
    logic [BYTE_W-1:0] data_type_code;
  } cfg_t;

  // classified item as it sits in the queue
  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] sender;
    logic [ID_W-1:0]   message_id;
    logic [BYTE_W-1:0] packet_type;
    logic [BYTE_W-1:0] hops_left;
    logic [ADDR_W-1:0] origin;
    logic [BYTE_W-1:0] app_id;
    logic              body_nz;
    logic              is_ping;
    logic              is_pong;
    logic              for_me;
    logic              terminal;
  } item_t;

  // declared MSB first: send_raw_pong lands in bit 0
  typedef struct packed {
    logic [ADDR_W-1:0] coordinator;
    logic              coordinator_known;
    logic              duplicate;
    logic [BYTE_W-1:0] relay_hops;
    logic              relay;
    logic              deliver;
    logic [BYTE_W-1:0] reply_hops;
    logic [BYTE_W-1:0] reply_app;
    logic [ADDR_W-1:0] reply_to;
    logic              send_reply;
    logic              raw_pong_seen;
    logic              send_raw_pong;
  } result_t;

endpackage

FILE: rtl/mesh_dedup_relay_filter.sv
// mesh_dedup_relay_filter: top level; configuration registers, front classifier,
// item queue and back decision unit. Uses mdrf_pkg, mdrf_front, mdrf_queue, mdrf_back.
//
// Receive-side filter of a flooding mesh. Each input item is one frame header
// (kind in tuser); each item yields exactly one result. A mesh packet passes the
// back unit as a load, one compare per ring slot and a decide; that ring scan
// sets the rate unless the output stalls. Other kinds go from load to decide.
// A two-entry queue buffers items ahead of the back unit and the output register
// lets the next item proceed while a result waits. The seen ring has valid bits
// cleared at reset, so no clearing pass is needed. Configuration is to be written
// by the user with cfg_we_i only while the block is idle; the block does not enforce it.
module mesh_dedup_relay_filter import mdrf_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CIDX_W-1:0]     cfg_idx_i,
  input  logic [ADDR_W-1:0]     cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // sender_address, message_id, packet_type, hops_left, destination,
  // origin_address, application_id, body_length
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // kind
  input  logic [KIND_W-1:0]     s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // send_raw_pong, raw_pong_seen, send_reply, reply_to, reply_app, reply_hops,
  // deliver, relay, relay_hops, duplicate, coordinator_known, coordinator, zero pad
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  cfg_t    cfg_q;
  item_t   front_item, q_item;
  logic    q_full, q_valid, q_pop;
  result_t res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.own_address       <= '0;
      cfg_q.broadcast_address <= '1;
      cfg_q.is_coordinator    <= 1'b0;
      cfg_q.ping_type_code    <= 8'd1;
      cfg_q.pong_type_code    <= 8'd2;
      cfg_q.data_type_code    <= 8'd3;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_OWN:   cfg_q.own_address       <= cfg_wdata_i;
        CFG_BCAST: cfg_q.broadcast_address <= cfg_wdata_i;
        CFG_COORD: cfg_q.is_coordinator    <= cfg_wdata_i[0];
        CFG_PING:  cfg_q.ping_type_code    <= cfg_wdata_i[BYTE_W-1:0];
        CFG_PONG:  cfg_q.pong_type_code    <= cfg_wdata_i[BYTE_W-1:0];
        CFG_DATA:  cfg_q.data_type_code    <= cfg_wdata_i[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !q_full;

  mdrf_front u_front (
    .tdata_i (s_axis_tdata),
    .tuser_i (s_axis_tuser),
    .cfg_i   (cfg_q),
    .item_o  (front_item)
  );

  mdrf_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (s_axis_tvalid),
    .data_i  (front_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .data_o  (q_item)
  );

  mdrf_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .is_coord_i  (cfg_q.is_coordinator),
    .q_valid_i   (q_valid),
    .q_data_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_o       (res)
  );

  assign m_axis_tdata = {1'b0, res};

endmodule

FILE: rtl/mdrf_front.sv
// mdrf_front: unpacks the input item, folds unused kinds into ignore and
// precomputes the address and type-code matches. Uses mdrf_pkg.
module mdrf_front import mdrf_pkg::*; (
  input  logic [IN_DATA_W-1:0] tdata_i,
  input  logic [KIND_W-1:0]    tuser_i,
  input  cfg_t                 cfg_i,
  output item_t                item_o
);

  logic [ADDR_W-1:0] dest;
  logic [BYTE_W-1:0] blen;
  logic              dest_own;

  assign dest     = tdata_i[143:96];
  assign blen     = tdata_i[207:200];
  assign dest_own = (dest == cfg_i.own_address);

  always_comb begin
    case (tuser_i)
      K_RAW_PING: item_o.kind = K_RAW_PING;
      K_RAW_PONG: item_o.kind = K_RAW_PONG;
      K_MESH:     item_o.kind = K_MESH;
      K_LOAD:     item_o.kind = K_LOAD;
      default:    item_o.kind = K_IGNORE;
    endcase
    item_o.sender      = tdata_i[47:0];
    item_o.message_id  = tdata_i[79:48];
    item_o.packet_type = tdata_i[87:80];
    item_o.hops_left   = tdata_i[95:88];
    item_o.origin      = tdata_i[191:144];
    item_o.app_id      = tdata_i[199:192];
    item_o.body_nz     = (blen != '0);
    item_o.is_ping     = (tdata_i[87:80] == cfg_i.ping_type_code);
    item_o.is_pong     = (tdata_i[87:80] == cfg_i.pong_type_code);
    item_o.for_me      = dest_own || (dest == cfg_i.broadcast_address);
    item_o.terminal    = (tdata_i[87:80] == cfg_i.data_type_code) && dest_own;
  end

endmodule

FILE: rtl/mdrf_queue.sv
// mdrf_queue: short FIFO of classified items between front and back.
// Uses mdrf_pkg.
module mdrf_queue import mdrf_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t data_i,
  output logic  full_o,
  input  logic  pop_i,
  output logic  valid_o,
  output item_t data_o
);

  item_t               mem_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QUEUE_CW-1:0] cnt_q, cnt_d;
  logic                do_push, do_pop;

  assign full_o  = (cnt_q == QUEUE_CW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  cnt_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QUEUE_CW'(QUEUE_DEPTH))
    else $error("queue count out of range");

  ptr_gap_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_q == rd_q))
    else $error("empty queue with pointers apart");

  no_push_full_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (full_o && !do_pop) |=> (cnt_q == QUEUE_CW'(QUEUE_DEPTH)))
    else $error("full queue changed without pop");

endmodule

FILE: rtl/mdrf_back.sv
// mdrf_back: scans the seen ring one slot a cycle, then decides reply,
// delivery, relay and coordinator capture into the output register. Uses mdrf_pkg.
module mdrf_back import mdrf_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    is_coord_i,
  input  logic    q_valid_i,
  input  item_t   q_data_i,
  output logic    q_pop_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  output result_t out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE
  } state_e;

  state_e             state_q;
  item_t              work_q;
  logic               hit_q;
  logic [SEEN_AW-1:0] idx_q;
  logic [SEEN_AW-1:0] pos_q;
  logic               out_valid_q;
  result_t            out_q;
  logic [ADDR_W-1:0]  cstore_q, cstore_d;
  logic               cflag_q, cflag_d;

  logic [ID_W-1:0]    seen_ids_q   [SEEN_DEPTH];
  logic [BYTE_W-1:0]  seen_types_q [SEEN_DEPTH];
  logic [SEEN_DEPTH-1:0] seen_valid_q;

  logic    slot_hit, out_free, record;
  result_t res;

  assign slot_hit = seen_valid_q[idx_q] && (seen_ids_q[idx_q] == work_q.message_id)
                    && (seen_types_q[idx_q] == work_q.packet_type);
  assign out_free = !out_valid_q || out_ready_i;
  assign q_pop_o  = (state_q == S_IDLE) && q_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign record = (state_q == S_DECIDE) && out_free && (work_q.kind == K_MESH) && !hit_q;

  always_comb begin
    res      = '0;
    cstore_d = cstore_q;
    cflag_d  = cflag_q;
    case (work_q.kind)
      K_RAW_PING: res.send_raw_pong = is_coord_i;
      K_RAW_PONG: begin
        res.raw_pong_seen = 1'b1;
        cstore_d          = work_q.sender;
      end
      K_LOAD: begin
        cstore_d = work_q.sender;
        cflag_d  = 1'b1;
      end
      K_MESH: begin
        if (hit_q) begin
          res.duplicate = 1'b1;
        end else begin
          if (work_q.is_ping) begin
            res.send_reply = 1'b1;
            res.reply_to   = work_q.origin;
            res.reply_app  = is_coord_i ? APP_COORD : APP_NODE;
            res.reply_hops = work_q.hops_left;
          end
          res.deliver = (work_q.is_ping && is_coord_i && work_q.body_nz)
                        || (work_q.for_me && !work_q.is_ping);
          if (!is_coord_i && work_q.is_pong && (work_q.app_id == APP_COORD)) begin
            cstore_d = work_q.origin;
            cflag_d  = 1'b1;
          end
          if ((work_q.hops_left != '0) && !work_q.terminal) begin
            res.relay      = 1'b1;
            res.relay_hops = work_q.hops_left - 1'b1;
          end
        end
      end
      default: ;
    endcase
    res.coordinator_known = cflag_d;
    res.coordinator       = cstore_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      hit_q        <= 1'b0;
      pos_q        <= '0;
      out_valid_q  <= 1'b0;
      cstore_q     <= '0;
      cflag_q      <= 1'b0;
      seen_valid_q <= '0;
    end else begin
      if ((state_q == S_DECIDE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (q_valid_i) begin
            idx_q   <= '0;
            hit_q   <= 1'b0;
            state_q <= (q_data_i.kind == K_MESH) ? S_SCAN : S_DECIDE;
          end
        end
        S_SCAN: begin
          hit_q <= hit_q || slot_hit;
          if (idx_q == SEEN_AW'(SEEN_DEPTH - 1)) begin
            state_q <= S_DECIDE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            cstore_q    <= cstore_d;
            cflag_q     <= cflag_d;
            state_q     <= S_IDLE;
            if (record) begin
              seen_valid_q[pos_q] <= 1'b1;
              pos_q <= (pos_q == SEEN_AW'(SEEN_DEPTH - 1)) ? '0 : pos_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      work_q <= q_data_i;
    end
    if ((state_q == S_DECIDE) && out_free) begin
      out_q <= res;
    end
    if (record) begin
      seen_ids_q[pos_q]   <= work_q.message_id;
      seen_types_q[pos_q] <= work_q.packet_type;
    end
  end

  scan_mesh_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (work_q.kind == K_MESH))
    else $error("ring scan for a non-mesh item");

  pos_range_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= SEEN_AW'(SEEN_DEPTH - 1))
    else $error("ring position out of range");

  decide_out_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DECIDE) && out_free) |=> out_valid_q)
    else $error("decision did not load the output register");

  dup_excl_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_q.duplicate && (out_q.relay || out_q.deliver || out_q.send_reply)))
    else $error("duplicate item with an action");

endmodule

FILE: tb/mesh_dedup_relay_filter_tb.sv
`timescale 1ns / 1ps
// mesh_dedup_relay_filter_tb: self-checking bench for the mesh duplicate/relay filter.
// Predicts every result from a private copy of ring, coordinator and register state.
// Depends on mdrf_pkg and mesh_dedup_relay_filter.
module mesh_dedup_relay_filter_tb;
  import mdrf_pkg::*;

  localparam int unsigned RING_SLOTS = SEEN_DEPTH;
  localparam int unsigned PHASES = 8;
  localparam int unsigned PHASE_ITEMS = 260;
  localparam int unsigned ID_POOL = 24;
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned PRINT_CAP = 60;
  localparam longint unsigned TIMEOUT_NS = 10_000_000;
  localparam logic [ADDR_W-1:0] ALL_ONES48 = '1;

  // sender_address in the low bits, as on s_axis_tdata
  typedef struct packed {
    logic [BYTE_W-1:0] body_length;
    logic [BYTE_W-1:0] application_id;
    logic [ADDR_W-1:0] origin_address;
    logic [ADDR_W-1:0] destination;
    logic [BYTE_W-1:0] hops_left;
    logic [BYTE_W-1:0] packet_type;
    logic [ID_W-1:0]   message_id;
    logic [ADDR_W-1:0] sender_address;
  } frame_hdr_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    frame_hdr_t        hdr;
  } frame_item_t;

  typedef enum logic [1:0] {RX_OPEN, RX_SPARSE, RX_PATTERN, RX_CHOKED} rx_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CIDX_W-1:0]     cfg_idx_i = CFG_OWN;
  logic [ADDR_W-1:0]     cfg_wdata_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [KIND_W-1:0]     s_axis_tuser = K_IGNORE;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  mesh_dedup_relay_filter dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  // predictor state
  cfg_t              node_cfg;
  logic [ID_W-1:0]   seen_id   [RING_SLOTS];
  logic [BYTE_W-1:0] seen_type [RING_SLOTS];
  logic              seen_ok   [RING_SLOTS];
  int unsigned       ring_wr;
  logic [ADDR_W-1:0] coord_addr;
  logic              coord_found;

  frame_item_t frame_pending [$];
  result_t     result_expect [$];
  int unsigned frames_queued = 0;
  int unsigned frames_taken = 0;
  int unsigned mismatch_count = 0;
  logic        frame_taken_flag = 1'b0;
  int unsigned burst_left = 0;
  int unsigned gap_left = 0;
  frame_item_t next_frame;
  rx_mode_e    rx_mode = RX_OPEN;
  int unsigned rx_left = 0;
  logic [7:0]  ready_ring = 8'b1011_0010;
  logic [ID_W-1:0] recent_id [ID_POOL];

  function automatic logic [ADDR_W-1:0] rand48();
    logic [63:0] v;
    v = {$urandom, $urandom};
    return v[ADDR_W-1:0];
  endfunction

  function automatic result_t predict_frame(logic [KIND_W-1:0] kind, frame_hdr_t h);
    result_t r;
    logic hit, is_ping, for_me, terminal;
    int unsigned i;
    r = '0;
    hit = 1'b0;
    case (kind)
      K_RAW_PING: r.send_raw_pong = node_cfg.is_coordinator;
      K_RAW_PONG: begin
        r.raw_pong_seen = 1'b1;
        coord_addr = h.sender_address;
      end
      K_LOAD: begin
        coord_addr = h.sender_address;
        coord_found = 1'b1;
      end
      K_MESH: begin
        for (i = 0; i < RING_SLOTS; i++)
          if (seen_ok[i] && seen_id[i] == h.message_id && seen_type[i] == h.packet_type)
            hit = 1'b1;
        if (hit) begin
          r.duplicate = 1'b1;
        end else begin
          is_ping = h.packet_type == node_cfg.ping_type_code;
          for_me = h.destination == node_cfg.own_address ||
                   h.destination == node_cfg.broadcast_address;
          terminal = h.packet_type == node_cfg.data_type_code &&
                     h.destination == node_cfg.own_address;
          seen_id[ring_wr] = h.message_id;
          seen_type[ring_wr] = h.packet_type;
          seen_ok[ring_wr] = 1'b1;
          ring_wr = (ring_wr + 1) % RING_SLOTS;
          if (is_ping) begin
            r.send_reply = 1'b1;
            r.reply_to = h.origin_address;
            r.reply_app = node_cfg.is_coordinator ? APP_COORD : APP_NODE;
            r.reply_hops = h.hops_left;
            if (node_cfg.is_coordinator && h.body_length != 0) r.deliver = 1'b1;
          end
          if (!node_cfg.is_coordinator && h.packet_type == node_cfg.pong_type_code &&
              h.application_id == APP_COORD) begin
            coord_addr = h.origin_address;
            coord_found = 1'b1;
          end
          if (for_me && !is_ping) r.deliver = 1'b1;
          if (h.hops_left != 0 && !terminal) begin
            r.relay = 1'b1;
            r.relay_hops = h.hops_left - 8'd1;
          end
        end
      end
      default: ;
    endcase
    r.coordinator_known = coord_found;
    r.coordinator = coord_addr;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (mismatch_count < PRINT_CAP)
      $display("%0t error: %s got 0x%0h expected 0x%0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_result(logic [OUT_DATA_W-1:0] raw, result_t want);
    result_t got;
    got = result_t'(raw[$bits(result_t)-1:0]);
    if (got.send_raw_pong !== want.send_raw_pong)
      report_mismatch("send_raw_pong", 64'(got.send_raw_pong), 64'(want.send_raw_pong));
    if (got.raw_pong_seen !== want.raw_pong_seen)
      report_mismatch("raw_pong_seen", 64'(got.raw_pong_seen), 64'(want.raw_pong_seen));
    if (got.send_reply !== want.send_reply)
      report_mismatch("send_reply", 64'(got.send_reply), 64'(want.send_reply));
    if (got.reply_to !== want.reply_to)
      report_mismatch("reply_to", 64'(got.reply_to), 64'(want.reply_to));
    if (got.reply_app !== want.reply_app)
      report_mismatch("reply_app", 64'(got.reply_app), 64'(want.reply_app));
    if (got.reply_hops !== want.reply_hops)
      report_mismatch("reply_hops", 64'(got.reply_hops), 64'(want.reply_hops));
    if (got.deliver !== want.deliver)
      report_mismatch("deliver", 64'(got.deliver), 64'(want.deliver));
    if (got.relay !== want.relay)
      report_mismatch("relay", 64'(got.relay), 64'(want.relay));
    if (got.relay_hops !== want.relay_hops)
      report_mismatch("relay_hops", 64'(got.relay_hops), 64'(want.relay_hops));
    if (got.duplicate !== want.duplicate)
      report_mismatch("duplicate", 64'(got.duplicate), 64'(want.duplicate));
    if (got.coordinator_known !== want.coordinator_known)
      report_mismatch("coordinator_known", 64'(got.coordinator_known),
                      64'(want.coordinator_known));
    if (got.coordinator !== want.coordinator)
      report_mismatch("coordinator", 64'(got.coordinator), 64'(want.coordinator));
    if (raw[OUT_DATA_W-1] !== 1'b0)
      report_mismatch("pad bit", 64'(raw[OUT_DATA_W-1]), '0);
  endtask

  // item acceptance and result checking
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) begin
      result_expect.push_back(predict_frame(s_axis_tuser, frame_hdr_t'(s_axis_tdata)));
      frames_taken++;
      frame_taken_flag = 1'b1;
    end
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (result_expect.size() == 0) report_mismatch("unexpected result", m_axis_tdata[63:0], '0);
      else check_result(m_axis_tdata, result_expect.pop_front());
    end
  end

  // sender: bursts of items with random gaps
  always @(negedge clk_i) begin
    if (!s_axis_tvalid || frame_taken_flag) begin
      frame_taken_flag = 1'b0;
      if (gap_left > 0 || frame_pending.size() == 0) begin
        if (gap_left > 0) gap_left--;
        s_axis_tvalid <= 1'b0;
      end else begin
        next_frame = frame_pending.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= next_frame.kind;
        s_axis_tdata <= next_frame.hdr;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 15);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
        end
      end
    end
  end

  // receiver: stall modes that change every so often
  always @(negedge clk_i) begin
    if (rx_left == 0) begin
      rx_mode = rx_mode_e'($urandom_range(0, 3));
      rx_left = $urandom_range(16, 160);
    end else begin
      rx_left--;
    end
    ready_ring = {ready_ring[6:0], ready_ring[7]};
    case (rx_mode)
      RX_OPEN:    m_axis_tready <= 1'b1;
      RX_SPARSE:  m_axis_tready <= ($urandom_range(0, 3) != 0);
      RX_PATTERN: m_axis_tready <= ready_ring[0];
      default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  task automatic queue_frame(frame_item_t f);
    frame_pending.push_back(f);
    frames_queued++;
  endtask

  task automatic wait_drained();
    while (frames_taken != frames_queued || result_expect.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(cfg_t c);
    logic [ADDR_W-1:0] noise;
    noise = rand48();
    wait_drained();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_OWN;
    cfg_wdata_i <= c.own_address;
    @(negedge clk_i);
    cfg_idx_i <= CFG_BCAST;
    cfg_wdata_i <= c.broadcast_address;
    @(negedge clk_i);
    cfg_idx_i <= CFG_COORD;
    cfg_wdata_i <= {noise[ADDR_W-1:1], c.is_coordinator};
    @(negedge clk_i);
    cfg_idx_i <= CFG_PING;
    cfg_wdata_i <= {noise[ADDR_W-1:BYTE_W], c.ping_type_code};
    @(negedge clk_i);
    cfg_idx_i <= CFG_PONG;
    cfg_wdata_i <= {~noise[ADDR_W-1:BYTE_W], c.pong_type_code};
    @(negedge clk_i);
    cfg_idx_i <= CFG_DATA;
    cfg_wdata_i <= {noise[ADDR_W-1:BYTE_W], c.data_type_code};
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    node_cfg = c;
  endtask

  function automatic frame_item_t plain_frame(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] sender);
    frame_item_t f;
    logic [223:0] noise;
    noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
    f.kind = kind;
    f.hdr = noise[IN_DATA_W-1:0];
    f.hdr.body_length = BYTE_W'($urandom_range(0, 200));
    f.hdr.sender_address = sender;
    return f;
  endfunction

  function automatic frame_item_t mesh_frame(logic [ID_W-1:0] id, logic [BYTE_W-1:0] ptype,
                                             logic [BYTE_W-1:0] hops, logic [ADDR_W-1:0] dest,
                                             logic [ADDR_W-1:0] origin, logic [BYTE_W-1:0] app,
                                             logic [BYTE_W-1:0] blen);
    frame_item_t f;
    f = plain_frame(K_MESH, rand48());
    f.hdr.message_id = id;
    f.hdr.packet_type = ptype;
    f.hdr.hops_left = hops;
    f.hdr.destination = dest;
    f.hdr.origin_address = origin;
    f.hdr.application_id = app;
    f.hdr.body_length = blen;
    return f;
  endfunction

  function automatic frame_item_t random_frame();
    frame_item_t f;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 72) begin
      f = plain_frame(K_MESH, rand48());
      if ($urandom_range(0, 9) < 6) f.hdr.message_id = recent_id[$urandom_range(0, ID_POOL - 1)];
      case ($urandom_range(0, 4))
        0: f.hdr.packet_type = node_cfg.ping_type_code;
        1: f.hdr.packet_type = node_cfg.pong_type_code;
        2: f.hdr.packet_type = node_cfg.data_type_code;
        default: ;
      endcase
      case ($urandom_range(0, 2))
        0: f.hdr.destination = node_cfg.own_address;
        1: f.hdr.destination = node_cfg.broadcast_address;
        default: ;
      endcase
      case ($urandom_range(0, 4))
        0: f.hdr.hops_left = 8'd0;
        1: f.hdr.hops_left = 8'd1;
        2: f.hdr.hops_left = 8'hFF;
        default: ;
      endcase
      if ($urandom_range(0, 9) < 4) f.hdr.application_id = APP_COORD;
      if ($urandom_range(0, 3) == 0) f.hdr.body_length = 8'd0;
    end else if (pick < 79) begin
      f = plain_frame(K_RAW_PING, rand48());
    end else if (pick < 85) begin
      f = plain_frame(K_RAW_PONG, rand48());
    end else if (pick < 90) begin
      f = plain_frame(K_LOAD, rand48());
    end else if (pick < 96) begin
      f = plain_frame(K_IGNORE, rand48());
    end else begin
      f = plain_frame(KIND_W'($urandom_range(5, 7)), rand48());
    end
    return f;
  endfunction

  function automatic cfg_t phase_settings(int unsigned p);
    cfg_t c;
    c.own_address = (p == 1) ? ALL_ONES48 : (p == 2) ? '0 : rand48();
    c.broadcast_address = (p == 3) ? '0 : (p == 4) ? ALL_ONES48 : rand48();
    c.is_coordinator = p[0];
    c.ping_type_code = BYTE_W'($urandom_range(0, 255));
    c.pong_type_code = BYTE_W'($urandom_range(0, 255));
    c.data_type_code = BYTE_W'($urandom_range(0, 255));
    if (p == 5) begin
      c.ping_type_code = 8'h00;
      c.pong_type_code = 8'h00;
      c.data_type_code = 8'h00;
    end else if (p == 6) begin
      c.ping_type_code = 8'hFF;
      c.pong_type_code = 8'hFF;
      c.data_type_code = 8'hFF;
    end else if (p == 7) begin
      c.pong_type_code = c.ping_type_code;
      c.data_type_code = c.ping_type_code;
    end
    return c;
  endfunction

  initial begin
    cfg_t c;
    int unsigned i;
    node_cfg.own_address = '0;
    node_cfg.broadcast_address = ALL_ONES48;
    node_cfg.is_coordinator = 1'b0;
    node_cfg.ping_type_code = 8'd1;
    node_cfg.pong_type_code = 8'd2;
    node_cfg.data_type_code = 8'd3;
    for (i = 0; i < RING_SLOTS; i++) begin
      seen_id[i] = '0;
      seen_type[i] = '0;
      seen_ok[i] = 1'b0;
    end
    ring_wr = 0;
    coord_addr = '0;
    coord_found = 1'b0;
    for (i = 0; i < ID_POOL; i++) recent_id[i] = (i < 4) ? i : $urandom;

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: a zero id/type pair must not hit the cleared ring
    queue_frame(mesh_frame(32'd0, 8'd0, 8'd0, '0, '0, 8'd0, 8'd0));
    queue_frame(mesh_frame(32'd0, 8'd0, 8'd0, '0, '0, 8'd0, 8'd0));
    queue_frame(plain_frame(K_RAW_PING, rand48()));
    queue_frame(plain_frame(K_RAW_PONG, 48'h1234_5678_9ABC));
    queue_frame(plain_frame(K_IGNORE, ALL_ONES48));
    queue_frame(plain_frame(3'd5, rand48()));
    queue_frame(plain_frame(3'd6, rand48()));
    queue_frame(plain_frame(3'd7, ALL_ONES48));
    queue_frame(mesh_frame(32'd1, 8'd1, 8'd7, ALL_ONES48, 48'hA5A5_0000_5A5A, 8'd3, 8'd5));
    queue_frame(mesh_frame(32'd2, 8'd3, 8'd9, '0, rand48(), 8'd0, 8'd200));
    queue_frame(mesh_frame(32'd3, 8'd3, 8'hFF, ALL_ONES48, rand48(), 8'd1, 8'd10));
    queue_frame(mesh_frame(32'd4, 8'd2, 8'd3, rand48(), 48'h0BAD_CAFE_F00D, APP_COORD, 8'd1));
    queue_frame(mesh_frame(32'd5, 8'd2, 8'd3, rand48(), rand48(), 8'hFE, 8'd1));
    queue_frame(mesh_frame('1, 8'hFF, 8'hFF, rand48(), ALL_ONES48, APP_COORD, 8'd200));
    queue_frame(plain_frame(K_LOAD, ALL_ONES48));

    // coordinator with overlapping type codes
    c.own_address = 48'h0000_1234_5678;
    c.broadcast_address = rand48();
    c.is_coordinator = 1'b1;
    c.ping_type_code = 8'h55;
    c.pong_type_code = 8'h55;
    c.data_type_code = 8'h55;
    load_settings(c);
    queue_frame(plain_frame(K_RAW_PING, rand48()));
    queue_frame(mesh_frame(32'd6, 8'h55, 8'd4, c.own_address, rand48(), APP_COORD, 8'd0));
    queue_frame(mesh_frame(32'd7, 8'h55, 8'd1, c.broadcast_address, rand48(), APP_COORD,
                           8'd200));
    queue_frame(mesh_frame(32'd8, 8'h00, 8'd2, c.own_address, rand48(), 8'd0, 8'd3));
    queue_frame(plain_frame(K_RAW_PONG, rand48()));

    for (i = 0; i < PHASES; i++) begin
      load_settings(phase_settings(i));
      repeat (PHASE_ITEMS) queue_frame(random_frame());
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (result_expect.size() != 0)
      report_mismatch("missing results", 64'(result_expect.size()), '0);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Mismatches found");
    $finish;
  end

endmodule
